// ===== rtl/i2cme_pkg.sv =====
`default_nettype none
package i2cme_pkg;

  // Request codes carried on req_type.
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Command in progress; the encodings follow the request codes.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Command lengths in SCL half-periods.
  localparam logic [4:0] LEN_START = 5'd3;
  localparam logic [4:0] LEN_STOP  = 5'd3;
  localparam logic [4:0] LEN_WRITE = 5'd20;
  localparam logic [4:0] LEN_READ  = 5'd22;

  // Divider register.
  localparam int unsigned DIV_W = 16;
  localparam logic [DIV_W-1:0] DIV_RESET = 16'd500;

  // Register map index of the divider.
  localparam logic REG_HALF_PERIOD = 1'b0;

  // Levels driven on the bus.
  typedef struct packed {
    logic scl;
    logic sda;
    logic released;
  } lines_t;

  // One result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       cmd_rejected;
  } res_t;

  function automatic logic [4:0] cmd_len(input cmd_e cmd);
    logic [4:0] len;
    case (cmd)
      CMD_START: len = LEN_START;
      CMD_STOP:  len = LEN_STOP;
      CMD_WRITE: len = LEN_WRITE;
      default:   len = LEN_READ;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cme_cfg.sv =====
`default_nettype none
module i2cme_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output logic [i2cme_pkg::DIV_W-1:0]    half_period_ticks
);
  import i2cme_pkg::*;

  logic wr_en;

  // The register is written on the access cycle of a write.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HALF_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= DIV_RESET;
    end else if (wr_en) begin
      half_period_ticks <= pwdata[DIV_W-1:0];
    end
  end

  // Read data; addresses past the map read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HALF_PERIOD) begin
      prdata = {{(32-DIV_W){1'b0}}, half_period_ticks};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2cme_seq.sv =====
`default_nettype none
module i2cme_seq (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic [2:0]                req_type,
  input  wire logic                      sda_in,
  input  wire logic [7:0]                wdata,
  input  wire logic                      send_ack,
  input  wire logic [i2cme_pkg::DIV_W-1:0] half_period_ticks,
  output i2cme_pkg::res_t                res
);
  import i2cme_pkg::*;

  cmd_e             active_cmd, active_cmd_next;
  logic [4:0]       phase_step, phase_step_next;
  logic [DIV_W-1:0] tick_count, tick_count_next;
  logic [7:0]       shift_reg, shift_reg_next;
  logic             ack_flag, ack_flag_next;
  logic             ack_to_send, ack_to_send_next;
  lines_t           lines, lines_next;
  logic [7:0]       last_read, last_read_next;
  logic             done, rejected;
  logic [DIV_W-1:0] tick_inc;
  logic [DIV_W-1:0] hp;
  logic [4:0]       phase_inc;

  // Line changes made at the start of half-period k.
  function automatic lines_t begin_step(input cmd_e cmd, input logic [4:0] k,
                                        input lines_t cur, input logic [7:0] sh,
                                        input logic ack);
    lines_t     l;
    logic [4:0] j;
    l = cur;
    j = k - 5'd1;
    case (cmd)
      CMD_START: begin
        if (k == 5'd0) begin
          l.released = 1'b0;
          l.sda      = 1'b1;
        end else if (k == 5'd1) begin
          l.scl = 1'b1;
        end else begin
          l.sda = 1'b0;
        end
      end
      CMD_STOP: begin
        if (k == 5'd0) l.sda = 1'b0;
        else if (k == 5'd1) l.scl = 1'b1;
        else l.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (k == 5'd0) begin
          l.scl = 1'b0;
        end else if (k <= 5'd16) begin
          // Data bits go out MSB first, one per SCL period.
          if (!j[0]) begin
            l.sda = sh[3'd7 - j[3:1]];
            l.scl = 1'b1;
          end else begin
            l.scl = 1'b0;
          end
        end else if (k == 5'd17) begin
          l.sda = 1'b1;
        end else if (k == 5'd18) begin
          l.released = 1'b1;
          l.scl      = 1'b1;
        end else begin
          l.scl = 1'b0;
        end
      end
      default: begin
        if (k == 5'd0) begin
          l.sda = 1'b1;
        end else if (k == 5'd1) begin
          l.scl = 1'b0;
        end else if (k <= 5'd17) begin
          if (k == 5'd2) l.released = 1'b1;
          l.scl = !k[0];
        end else if (k == 5'd18) begin
          l.released = 1'b0;
          l.sda      = !ack;
        end else if (k == 5'd19) begin
          l.scl = 1'b1;
        end else if (k == 5'd20) begin
          l.scl = 1'b0;
        end else begin
          l.sda = 1'b1;
        end
      end
    endcase
    return l;
  endfunction

  // A divider of zero counts as one.
  assign hp        = (half_period_ticks == '0) ? {{(DIV_W-1){1'b0}}, 1'b1}
                                               : half_period_ticks;
  assign tick_inc  = tick_count + {{(DIV_W-1){1'b0}}, 1'b1};
  assign phase_inc = phase_step + 5'd1;

  // Next state for one accepted item.
  always_comb begin
    active_cmd_next  = active_cmd;
    phase_step_next  = phase_step;
    tick_count_next  = tick_count;
    shift_reg_next   = shift_reg;
    ack_flag_next    = ack_flag;
    ack_to_send_next = ack_to_send;
    lines_next       = lines;
    last_read_next   = last_read;
    done             = 1'b0;
    rejected         = 1'b0;

    if (req_type == REQ_START || req_type == REQ_STOP ||
        req_type == REQ_WRITE || req_type == REQ_READ) begin
      if (active_cmd != CMD_IDLE) begin
        rejected = 1'b1;
      end else begin
        active_cmd_next = cmd_e'(req_type);
        phase_step_next = '0;
        tick_count_next = '0;
        if (req_type == REQ_WRITE) shift_reg_next = wdata;
        if (req_type == REQ_READ) begin
          shift_reg_next   = '0;
          ack_to_send_next = send_ack;
        end
        lines_next = begin_step(cmd_e'(req_type), 5'd0, lines, wdata, send_ack);
      end
    end else if (req_type == REQ_TICK && active_cmd != CMD_IDLE) begin
      tick_count_next = tick_inc;
      if (tick_inc >= hp || tick_inc == '0) begin
        tick_count_next = '0;
        // Samples at the end of the half-period.
        if (active_cmd == CMD_WRITE && phase_step == 5'd18) begin
          ack_flag_next = !sda_in;
        end else if (active_cmd == CMD_READ && phase_step >= 5'd2 &&
                     phase_step <= 5'd16 && !phase_step[0]) begin
          shift_reg_next = {shift_reg[6:0], sda_in};
        end
        if (phase_inc >= cmd_len(active_cmd)) begin
          if (active_cmd == CMD_WRITE) begin
            lines_next.sda      = 1'b0;
            lines_next.released = 1'b0;
          end
          if (active_cmd == CMD_READ) last_read_next = shift_reg_next;
          active_cmd_next = CMD_IDLE;
          phase_step_next = '0;
          done            = 1'b1;
        end else begin
          phase_step_next = phase_inc;
          lines_next = begin_step(active_cmd, phase_inc, lines, shift_reg_next,
                                  ack_to_send);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cmd  <= CMD_IDLE;
      phase_step  <= '0;
      tick_count  <= '0;
      shift_reg   <= '0;
      ack_flag    <= 1'b0;
      ack_to_send <= 1'b0;
      lines       <= '{scl: 1'b1, sda: 1'b1, released: 1'b0};
      last_read   <= '0;
    end else if (accept) begin
      active_cmd  <= active_cmd_next;
      phase_step  <= phase_step_next;
      tick_count  <= tick_count_next;
      shift_reg   <= shift_reg_next;
      ack_flag    <= ack_flag_next;
      ack_to_send <= ack_to_send_next;
      lines       <= lines_next;
      last_read   <= last_read_next;
    end
  end

  // Result of the item being accepted, taken after its update.
  always_comb begin
    res.scl_level    = lines_next.scl;
    res.sda_level    = lines_next.sda;
    res.sda_released = lines_next.released;
    res.busy_res     = (active_cmd_next != CMD_IDLE);
    res.done_res     = done;
    res.read_byte    = last_read_next;
    res.ack_seen     = ack_flag_next;
    res.cmd_rejected = rejected;
  end

  // An idle engine sits at the first half-period.
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    active_cmd == CMD_IDLE |-> phase_step == 5'd0)
    else $error("idle engine with nonzero phase");

  // A running command never passes its own length.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    active_cmd != CMD_IDLE |-> phase_step < cmd_len(active_cmd))
    else $error("phase beyond command length");

  // A completed command leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> active_cmd == CMD_IDLE)
    else $error("engine busy after done");

endmodule
`default_nettype wire

// ===== rtl/i2cme_skid.sv =====
`default_nettype none
module i2cme_skid (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  i2cme_pkg::res_t      push_data,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output i2cme_pkg::res_t      out_data
);
  import i2cme_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Control: the skid entry fills only while the output register holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // The skid entry is only in use behind a waiting result.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output item");

  // Nothing is pushed into a full buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("push into full output buffer");

endmodule
`default_nettype wire

// ===== rtl/i2c_master_byte_engine_top.sv =====
`default_nettype none
// Channel  | Handshake                     | Payload
// input    | in_valid / in_stall           | req_type, sda_in, wdata, send_ack
// output   | out_valid / out_stall         | scl_level .. cmd_rejected
// config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One result item per input item; one item can be accepted every cycle
// while in_stall is low. State and result are computed from the accepted item;
// the result is registered at acceptance, into the skid entry if the output holds.
// A two-entry output buffer absorbs one stall; in_stall rises when both are full.
// Synchronous reset puts the bus lines at SCL high, SDA driven high, idle.
module i2c_master_byte_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic        sda_in,
  input  wire logic [7:0]  wdata,
  input  wire logic        send_ack,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_released,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       read_byte,
  output logic             ack_seen,
  output logic             cmd_rejected,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import i2cme_pkg::*;

  logic             accept;
  logic [DIV_W-1:0] half_period_ticks;
  res_t             res;
  res_t             out_res;

  assign accept = in_valid && !in_stall;

  i2cme_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .half_period_ticks (half_period_ticks)
  );

  i2cme_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .req_type          (req_type),
    .sda_in            (sda_in),
    .wdata             (wdata),
    .send_ack          (send_ack),
    .half_period_ticks (half_period_ticks),
    .res               (res)
  );

  i2cme_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // Result fields onto their ports.
  assign scl_level    = out_res.scl_level;
  assign sda_level    = out_res.sda_level;
  assign sda_released = out_res.sda_released;
  assign busy_res     = out_res.busy_res;
  assign done_res     = out_res.done_res;
  assign read_byte    = out_res.read_byte;
  assign ack_seen     = out_res.ack_seen;
  assign cmd_rejected = out_res.cmd_rejected;

endmodule
`default_nettype wire
